// ----- src/stws_pkg.sv -----
// ---------------------------------------------------------------------------
// stws_pkg
// Shared types and constants for the sliding time window statistics block.
// ---------------------------------------------------------------------------
package stws_pkg;

	localparam int DEPTH  = 32;
	localparam int IDX_W  = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int TIME_W = 32;
	localparam int VAL_W  = 16;
	localparam int WLEN_W = 31;
	localparam int MODE_W = 4;
	localparam int OH_W   = 8;
	localparam int CAP_W  = 40;
	localparam int RES_W  = 40;
	localparam int ST_W   = 2;
	localparam int SUM_W  = VAL_W + CNT_W;
	localparam int DIV_W  = 40;
	localparam int FRAC_BITS = 8;
	localparam int ENT_W  = TIME_W + VAL_W;
	localparam int IN_W   = TIME_W + VAL_W;
	localparam int OUT_W  = TIME_W + RES_W;
	localparam int ADDR_W = 5;
	localparam int DATA_W = 64;

	// 100 % with 8 fraction bits (100 * 256)
	localparam logic [DIV_W-1:0] PCT_SCALED = DIV_W'(100 * 256);

	localparam logic [MODE_W-1:0] MODE_COUNT = 4'd0;
	localparam logic [MODE_W-1:0] MODE_SUM   = 4'd1;
	localparam logic [MODE_W-1:0] MODE_AVG   = 4'd2;
	localparam logic [MODE_W-1:0] MODE_MIN   = 4'd3;
	localparam logic [MODE_W-1:0] MODE_MAX   = 4'd4;
	localparam logic [MODE_W-1:0] MODE_RANGE = 4'd5;
	localparam logic [MODE_W-1:0] MODE_SHARE = 4'd6;
	localparam logic [MODE_W-1:0] MODE_LOAD  = 4'd7;
	localparam logic [MODE_W-1:0] MODE_FREE  = 4'd8;

	localparam logic [ST_W-1:0] STAT_OK    = 2'd0;
	localparam logic [ST_W-1:0] STAT_ORDER = 2'd1;
	localparam logic [ST_W-1:0] STAT_FULL  = 2'd2;

	localparam logic [1:0] REG_WLEN = 2'd0;
	localparam logic [1:0] REG_MODE = 2'd1;
	localparam logic [1:0] REG_OH   = 2'd2;
	localparam logic [1:0] REG_CAP  = 2'd3;

	typedef struct packed {
		logic [WLEN_W-1:0] wlen;
		logic [MODE_W-1:0] mode;
		logic [OH_W-1:0]   oh;
		logic [CAP_W-1:0]  cap;
	} cfg_t;

	typedef enum logic [1:0] {RD_OLDEST, RD_NEWEST, RD_WALK} rdsel_t;
	typedef enum logic [1:0] {KIND_DROP, KIND_GAP, KIND_FINAL, KIND_ERR} kind_t;

	typedef enum logic [3:0] {
		S_IDLE, S_CHECK, S_OLD_CMP, S_STAT, S_WALK, S_WALK_END, S_CALC,
		S_DIV, S_GAP, S_DUP_RD, S_DUP_CMP, S_EMIT
	} state_t;

	typedef struct packed {
		logic   in_load;
		rdsel_t rd_sel;
		logic   drop;
		logic   store;
		logic   mark_full;
		logic   walk_clr;
		logic   walk_issue;
		logic   calc;
		logic   emit;
		kind_t  kind;
		logic   commit;
	} cmd_t;

	typedef struct packed {
		logic lt_prev;
		logic count_zero;
		logic old_expired;
		logic gap;
		logic dup;
		logic full;
		logic walk_last;
		logic stat_ready;
		logic out_free;
	} sts_t;

endpackage

// ----- src/sliding_time_window_statistics.sv -----
// A rejected (out-of-order) item gives only an error result, with no walk. Each dropped
// sample and the final statistic walk every entry of the window (a gap result may come first),
// and average, share, load and free modes then use the shared restoring divider.
// One item at a time; the next item is taken while the last result waits in the output stage.
// Reset (arst_n low, asynchronous) empties the window and restores register defaults.
// ---------------------------------------------------------------------------
// sliding_time_window_statistics
// Timestamped samples in a ring; statistics over the sliding window.
// ---------------------------------------------------------------------------
module sliding_time_window_statistics (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [stws_pkg::IN_W-1:0]   s_tdata,  // sample_time[31:0], sample_value[47:32]
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [stws_pkg::OUT_W-1:0]  m_tdata,  // result_time[31:0], result_value[71:32]
	output logic [stws_pkg::ST_W-1:0]   m_tuser,  // status[1:0]
	output logic                        m_tlast,  // last_result
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [stws_pkg::ADDR_W-1:0] paddr,
	input  logic [stws_pkg::DATA_W-1:0] pwdata,
	output logic [stws_pkg::DATA_W-1:0] prdata,
	output logic                        pready
);
	import stws_pkg::*;

	cfg_t cfg;
	cmd_t cmd;
	sts_t sts;

	// registers at byte addresses 0, 8, 16, 24
	stws_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// sequencer: one item from accept to final result
	stws_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// ring memory, walk accumulators, divider and output stage
	stws_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.cmd        (cmd),
		.sts        (sts),
		.in_data    (s_tdata),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_data   (m_tdata),
		.out_status (m_tuser),
		.out_last   (m_tlast)
	);

endmodule

// ----- src/stws_regs.sv -----
// ---------------------------------------------------------------------------
// stws_regs
// Configuration registers behind the APB-style port.
// ---------------------------------------------------------------------------
module stws_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [stws_pkg::ADDR_W-1:0] paddr,
	input  logic [stws_pkg::DATA_W-1:0] pwdata,
	output logic [stws_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	output stws_pkg::cfg_t              cfg
);
	import stws_pkg::*;

	cfg_t cfg_q;
	logic wr;
	logic [1:0] idx;

	assign pready = 1'b1;
	assign wr     = psel & penable & pwrite & pready;
	assign idx    = paddr[ADDR_W-1:ADDR_W-2];
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.wlen <= WLEN_W'(1000000);
			cfg_q.mode <= MODE_COUNT;
			cfg_q.oh   <= OH_W'(38);
			cfg_q.cap  <= CAP_W'(1000000);
		end else if (wr) begin
			case (idx)
				REG_WLEN: cfg_q.wlen <= pwdata[WLEN_W-1:0];
				REG_MODE: cfg_q.mode <= pwdata[MODE_W-1:0];
				REG_OH:   cfg_q.oh   <= pwdata[OH_W-1:0];
				REG_CAP:  cfg_q.cap  <= pwdata[CAP_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_WLEN: prdata = DATA_W'(cfg_q.wlen);
			REG_MODE: prdata = DATA_W'(cfg_q.mode);
			REG_OH:   prdata = DATA_W'(cfg_q.oh);
			REG_CAP:  prdata = DATA_W'(cfg_q.cap);
			default:  prdata = '0;
		endcase
	end

endmodule

// ----- src/stws_div.sv -----
// ---------------------------------------------------------------------------
// stws_div
// Restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module stws_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [stws_pkg::DIV_W-1:0] num,
	input  logic [stws_pkg::DIV_W-1:0] den,
	output logic                       busy,
	output logic                       done,
	output logic [stws_pkg::DIV_W-1:0] quo
);
	import stws_pkg::*;

	localparam int CW = $clog2(DIV_W + 1);

	logic [DIV_W:0]   rem_q;
	logic [DIV_W-1:0] quo_q;
	logic [DIV_W-1:0] den_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DIV_W:0]   rem_sh;
	logic [DIV_W:0]   diff;

	assign rem_sh = {rem_q[DIV_W-1:0], quo_q[DIV_W-1]};
	assign diff   = rem_sh - {1'b0, den_q};
	assign busy   = busy_q;
	assign done   = done_q;
	assign quo    = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			if (!diff[DIV_W]) begin
				rem_q <= diff;
				quo_q <= {quo_q[DIV_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[DIV_W-2:0], 1'b0};
			end
		end
	end

endmodule

// ----- src/stws_dp.sv -----
// ---------------------------------------------------------------------------
// stws_dp
// Datapath: sample ring, window walk, statistic and result register.
// ---------------------------------------------------------------------------
module stws_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  stws_pkg::cfg_t              cfg,
	input  stws_pkg::cmd_t              cmd,
	output stws_pkg::sts_t              sts,
	input  logic [stws_pkg::IN_W-1:0]   in_data,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [stws_pkg::OUT_W-1:0]  out_data,
	output logic [stws_pkg::ST_W-1:0]   out_status,
	output logic                        out_last
);
	import stws_pkg::*;

	function automatic logic [IDX_W-1:0] slot(input logic [IDX_W-1:0] base,
		input logic [IDX_W-1:0] off);
		logic [IDX_W:0] s;
		s = {1'b0, base} + {1'b0, off};
		if (s >= (IDX_W+1)'(DEPTH))
			s = s - (IDX_W+1)'(DEPTH);
		return s[IDX_W-1:0];
	endfunction

	logic [ENT_W-1:0]  mem [DEPTH];
	logic [ENT_W-1:0]  rd_q;
	logic [IDX_W-1:0]  rd_addr;
	logic [IDX_W-1:0]  wr_addr;

	logic [TIME_W-1:0] t_q;
	logic [VAL_W-1:0]  v_q;
	logic [TIME_W-1:0] prev_q;
	logic [IDX_W-1:0]  oldest_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  cnt_m1;
	logic              full_q;
	logic [TIME_W-1:0] drop_time_q;

	logic [IDX_W-1:0]  k_q;
	logic              acc_v_q;
	logic              first_q;
	logic [SUM_W-1:0]  sum_q;
	logic [VAL_W-1:0]  mn_q;
	logic [VAL_W-1:0]  mx_q;
	logic [RES_W-1:0]  stat_q;

	logic [TIME_W-1:0] rd_time;
	logic [VAL_W-1:0]  rd_val;
	logic [TIME_W:0]   old_sum;

	logic              out_valid_q;
	logic [OUT_W-1:0]  out_data_q;
	logic [ST_W-1:0]   out_status_q;
	logic              out_last_q;

	// statistic operands
	logic [DIV_W-1:0]  prod_pct;
	logic [DIV_W-1:0]  den_share;
	logic [DIV_W-1:0]  d_num;
	logic [DIV_W-1:0]  d_den;
	logic              use_div;
	logic [RES_W-1:0]  direct;
	logic              div_busy;
	logic              div_done;
	logic [DIV_W-1:0]  div_quo;

	logic [TIME_W-1:0] e_time;
	logic [RES_W-1:0]  e_val;
	logic [ST_W-1:0]   e_st;

	assign rd_time = rd_q[TIME_W-1:0];
	assign rd_val  = rd_q[ENT_W-1:TIME_W];
	assign cnt_m1  = count_q - 1'b1;
	assign old_sum = {1'b0, rd_time} + (TIME_W+1)'(cfg.wlen);

	always_comb begin
		case (cmd.rd_sel)
			RD_OLDEST: rd_addr = oldest_q;
			RD_NEWEST: rd_addr = slot(oldest_q, cnt_m1[IDX_W-1:0]);
			RD_WALK:   rd_addr = slot(oldest_q, k_q);
			default:   rd_addr = oldest_q;
		endcase
	end
	assign wr_addr = slot(oldest_q, count_q[IDX_W-1:0]);

	always_ff @(posedge clk) begin
		if (cmd.store)
			mem[wr_addr] <= {v_q, t_q};
		rd_q <= mem[rd_addr];
	end

	assign sts.lt_prev     = t_q < prev_q;
	assign sts.count_zero  = count_q == '0;
	assign sts.old_expired = old_sum < {1'b0, t_q};
	assign sts.gap         = (t_q - prev_q) > {cfg.wlen, 1'b0};
	assign sts.dup         = rd_time == t_q;
	assign sts.full        = count_q == CNT_W'(DEPTH);
	assign sts.walk_last   = {{(CNT_W-IDX_W){1'b0}}, k_q} == cnt_m1;
	assign sts.stat_ready  = !div_busy;
	assign sts.out_free    = !out_valid_q || out_ready;

	// ring state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oldest_q <= '0;
			count_q  <= '0;
			prev_q   <= '0;
			full_q   <= 1'b0;
		end else begin
			if (cmd.in_load)
				full_q <= 1'b0;
			if (cmd.mark_full)
				full_q <= 1'b1;
			if (cmd.drop) begin
				oldest_q <= slot(oldest_q, IDX_W'(1));
				count_q  <= count_q - 1'b1;
			end else if (cmd.store) begin
				count_q <= count_q + 1'b1;
			end
			if (cmd.commit)
				prev_q <= t_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.in_load) begin
			t_q <= in_data[TIME_W-1:0];
			v_q <= in_data[IN_W-1:TIME_W];
		end
		if (cmd.drop)
			drop_time_q <= old_sum[TIME_W] ? '1 : old_sum[TIME_W-1:0];
	end

	// window walk: one entry per cycle, read data registered and used in the cycle after its address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			acc_v_q <= 1'b0;
		else
			acc_v_q <= cmd.walk_issue;
	end

	always_ff @(posedge clk) begin
		if (cmd.walk_clr) begin
			k_q     <= '0;
			sum_q   <= '0;
			mn_q    <= '0;
			mx_q    <= '0;
			first_q <= 1'b1;
		end else begin
			if (cmd.walk_issue)
				k_q <= k_q + 1'b1;
			if (acc_v_q) begin
				sum_q   <= sum_q + SUM_W'(rd_val);
				first_q <= 1'b0;
				if (first_q || rd_val < mn_q)
					mn_q <= rd_val;
				if (rd_val > mx_q)
					mx_q <= rd_val;
			end
		end
	end

	// statistic select; divisions round half up via num + den/2
	assign prod_pct  = DIV_W'(sum_q) * PCT_SCALED;
	assign den_share = DIV_W'(sum_q) + DIV_W'(cfg.oh) * DIV_W'(count_q);

	always_comb begin
		use_div = 1'b0;
		direct  = '0;
		d_num   = prod_pct;
		d_den   = DIV_W'(cfg.cap);
		case (cfg.mode)
			MODE_COUNT: direct = RES_W'(count_q) << FRAC_BITS;
			MODE_SUM:   direct = RES_W'(sum_q) << FRAC_BITS;
			MODE_AVG: begin
				use_div = count_q != '0;
				d_num   = DIV_W'(sum_q) << FRAC_BITS;
				d_den   = DIV_W'(count_q);
			end
			MODE_MIN:   direct = RES_W'(mn_q) << FRAC_BITS;
			MODE_MAX:   direct = RES_W'(mx_q) << FRAC_BITS;
			MODE_RANGE: direct = RES_W'(mx_q - mn_q) << FRAC_BITS;
			MODE_SHARE: begin
				use_div = den_share != '0;
				d_den   = den_share;
			end
			MODE_LOAD:  use_div = cfg.cap != '0;
			MODE_FREE: begin
				use_div = cfg.cap != '0;
				direct  = RES_W'(PCT_SCALED);
			end
			default: direct = '0;
		endcase
	end

	stws_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.calc & use_div),
		.num    (d_num + (d_den >> 1)),
		.den    (d_den),
		.busy   (div_busy),
		.done   (div_done),
		.quo    (div_quo)
	);

	// no clamp: in free mode a load above 100 % wraps the unsigned result
	always_ff @(posedge clk) begin
		if (cmd.calc && !use_div)
			stat_q <= direct;
		else if (div_done)
			stat_q <= (cfg.mode == MODE_FREE) ? RES_W'(PCT_SCALED - div_quo)
				: RES_W'(div_quo);
	end

	// result register
	always_comb begin
		e_time = t_q;
		e_val  = '0;
		e_st   = STAT_OK;
		case (cmd.kind)
			KIND_DROP: begin
				e_time = drop_time_q;
				e_val  = stat_q;
			end
			KIND_GAP:   e_time = t_q - TIME_W'(cfg.wlen);
			KIND_FINAL: begin
				e_val = stat_q;
				e_st  = full_q ? STAT_FULL : STAT_OK;
			end
			KIND_ERR:   e_st = STAT_ORDER;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.emit)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_data_q   <= {e_val, e_time};
			out_status_q <= e_st;
			out_last_q   <= (cmd.kind == KIND_FINAL) || (cmd.kind == KIND_ERR);
		end
	end

	assign out_valid  = out_valid_q;
	assign out_data   = out_data_q;
	assign out_status = out_status_q;
	assign out_last   = out_last_q;

endmodule

// ----- src/stws_ctrl.sv -----
// ---------------------------------------------------------------------------
// stws_ctrl
// Sequencer: drop, gap, store and statistic steps of one item.
// ---------------------------------------------------------------------------
module stws_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  stws_pkg::sts_t sts,
	output stws_pkg::cmd_t cmd
);
	import stws_pkg::*;

	state_t state_q, state_d;
	kind_t  kind_q, kind_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			kind_q  <= KIND_FINAL;
		end else begin
			state_q <= state_d;
			kind_q  <= kind_d;
		end
	end

	always_comb begin
		state_d = state_q;
		kind_d  = kind_q;
		case (state_q)
			S_IDLE:
				if (in_valid)
					state_d = S_CHECK;
			S_CHECK:
				if (sts.lt_prev) begin
					kind_d  = KIND_ERR;
					state_d = S_EMIT;
				end else if (sts.count_zero) begin
					state_d = S_GAP;
				end else begin
					state_d = S_OLD_CMP;
				end
			S_OLD_CMP:
				if (sts.old_expired) begin
					kind_d  = KIND_DROP;
					state_d = S_STAT;
				end else begin
					state_d = S_GAP;
				end
			S_STAT:     state_d = sts.count_zero ? S_CALC : S_WALK;
			S_WALK:
				if (sts.walk_last)
					state_d = S_WALK_END;
			S_WALK_END: state_d = S_CALC;
			S_CALC:     state_d = S_DIV;
			S_DIV:
				if (sts.stat_ready)
					state_d = S_EMIT;
			S_GAP:
				if (sts.gap) begin
					kind_d  = KIND_GAP;
					state_d = S_EMIT;
				end else begin
					state_d = S_DUP_RD;
				end
			S_DUP_RD: begin
				kind_d  = KIND_FINAL;
				state_d = sts.count_zero ? S_STAT : S_DUP_CMP;
			end
			S_DUP_CMP:  state_d = S_STAT;
			S_EMIT:
				if (sts.out_free) begin
					case (kind_q)
						KIND_DROP: state_d = S_CHECK;
						KIND_GAP:  state_d = S_DUP_RD;
						default:   state_d = S_IDLE;
					endcase
				end
			default:    state_d = S_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		cmd      = '0;
		cmd.rd_sel = RD_OLDEST;
		cmd.kind   = kind_q;
		case (state_q)
			S_IDLE: begin
				in_ready    = 1'b1;
				cmd.in_load = in_valid;
			end
			S_OLD_CMP:  cmd.drop = sts.old_expired;
			S_STAT:     cmd.walk_clr = 1'b1;
			S_WALK: begin
				cmd.rd_sel     = RD_WALK;
				cmd.walk_issue = 1'b1;
			end
			S_CALC:     cmd.calc = 1'b1;
			S_DUP_RD:
				if (sts.count_zero)
					cmd.store = 1'b1;
				else
					cmd.rd_sel = RD_NEWEST;
			S_DUP_CMP:
				if (!sts.dup) begin
					cmd.mark_full = sts.full;
					cmd.store     = !sts.full;
				end
			S_EMIT: begin
				cmd.emit   = sts.out_free;
				cmd.commit = sts.out_free && (kind_q == KIND_FINAL);
			end
			default: ;
		endcase
	end

endmodule
